/* hw/rtl/gzla_pkg.sv */
// Shared types, constants and modular-arithmetic helpers for the GF(q) Zech-log ALU.
// No dependencies; every other file imports this package.
`default_nettype none

package gzla_pkg;

  localparam int VW          = 16;           // element log width
  localparam int EW          = 31;           // exponent width
  localparam int PW          = VW + EW;      // pow product width
  localparam int OPW         = 3;            // command width
  localparam int IN_DW       = 96;           // input tdata width, padded to bytes
  localparam int OUT_UW      = 5;            // output tuser width
  localparam int CFG_IW      = 1;            // config index width
  localparam int RED_A_STEPS = VW;           // steps to reduce a 16-bit value mod m
  localparam int RED_E_STEPS = EW;           // steps to reduce x < m * 2^31 mod m
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = 2;
  localparam int DEFAULT_TABLE_DEPTH = 65536;

  // input tdata field offsets
  localparam int A_LSB    = 0;
  localparam int B_LSB    = A_LSB + VW;
  localparam int E_LSB    = B_LSB + VW;
  localparam int IDX_LSB  = E_LSB + EW;
  localparam int TVAL_LSB = IDX_LSB + VW;

  // output tuser bit positions
  localparam int UB_DZ   = 0;
  localparam int UB_ZERO = 1;
  localparam int UB_ONE  = 2;
  localparam int UB_MONE = 3;
  localparam int UB_EQ   = 4;

  localparam logic [CFG_IW-1:0] CFG_FIELD_ORDER = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_MINUS_ONE   = 1'd1;

  localparam logic [VW-1:0] FIELD_ORDER_RST = 16'd4;
  localparam logic [VW-1:0] MINUS_ONE_RST   = 16'd0;

  typedef enum logic [OPW-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_INV  = 3'd5,
    OP_POW  = 3'd6,
    OP_LOAD = 3'd7
  } op_t;

  // classified item handed from the front to the back
  typedef struct packed {
    op_t           op;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [EW-1:0] e;
    logic [VW-1:0] idx;
    logic [VW-1:0] tval;
    logic          a_zero;
    logic          b_zero;
    logic          e_zero;
    logic          eq;
  } dec_t;

  // per-item control carried down the back pipeline
  typedef struct packed {
    op_t           op;
    logic          eq;
    logic          dz;
    logic          direct;   // res already final
    logic [VW-1:0] res;
  } tag_t;

  // (x + y) mod m for x, y < m
  function automatic logic [VW-1:0] mod_add(input logic [VW-1:0] x, input logic [VW-1:0] y,
                                            input logic [VW-1:0] m);
    logic [VW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[VW-1:0];
  endfunction

  // (x - y) mod m for x, y < m
  function automatic logic [VW-1:0] mod_sub(input logic [VW-1:0] x, input logic [VW-1:0] y,
                                            input logic [VW-1:0] m);
    logic [VW-1:0] r;
    if (x >= y) r = x - y;
    else r = x + (m - y);
    return r;
  endfunction

  // one restoring step: subtract m << j when it fits
  function automatic logic [VW-1:0] red16_step(input logic [VW-1:0] rem, input logic [VW-1:0] m,
                                               input int j);
    logic [2*VW-1:0] ms;
    logic [2*VW-1:0] rx;
    ms = {{VW{1'b0}}, m} << j;
    rx = {{VW{1'b0}}, rem};
    if (rx >= ms) rx = rx - ms;
    return rx[VW-1:0];
  endfunction

  function automatic logic [PW-1:0] red47_step(input logic [PW-1:0] rem, input logic [VW-1:0] m,
                                               input int j);
    logic [PW+VW-1:0] ms;
    logic [PW+VW-1:0] rx;
    ms = {{PW{1'b0}}, m} << j;
    rx = {{VW{1'b0}}, rem};
    if (rx >= ms) rx = rx - ms;
    return rx[PW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gf_zech_log_alu_core.sv */
// Top level of the GF(q) Zech-log ALU: config registers, front, queue and back pipeline.
// Depends on gzla_pkg, gzla_front, gzla_queue and gzla_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in_     | slave     | in_tvalid/in_tready  | tuser cmd; tdata a, b, exponent, idx, value
//   out_    | master    | out_tvalid/out_tready| tdata result; tuser five status flags
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// Sustains one transaction per cycle while the result register is not stalled by out_tready.
// The back pipeline holds two restoring mod-(q-1) reducers (16 and 31 steps) plus table and ops.
// Load transactions write the Zech table and produce no result.
// Reset is synchronous, active low; the table holds no reset value and needs no clearing.
// A stalled result register freezes the back pipeline; the 4-entry queue keeps input open until it fills.
`default_nettype none

module gf_zech_log_alu_core #(
  parameter int TABLE_DEPTH = gzla_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gzla_pkg::IN_DW-1:0]  in_tdata,   // operand_a[15:0], operand_b[31:16],
                                                  // exponent[62:32], table_index[78:63],
                                                  // table_value[94:79], zero pad[95]
  input  logic [gzla_pkg::OPW-1:0]    in_tuser,   // cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gzla_pkg::VW-1:0]     out_tdata,  // result_value
  output logic [gzla_pkg::OUT_UW-1:0] out_tuser,  // div_by_zero, result_is_zero,
                                                  // result_is_one, result_is_minus_one,
                                                  // operands_equal
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gzla_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gzla_pkg::VW-1:0]     cfg_data
);
  import gzla_pkg::*;

  logic [VW-1:0] field_order_r, field_order_nxt;
  logic [VW-1:0] minus_one_log_r, minus_one_log_nxt;
  logic          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    field_order_nxt   = field_order_r;
    minus_one_log_nxt = minus_one_log_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_FIELD_ORDER: field_order_nxt   = cfg_data;
        CFG_MINUS_ONE:   minus_one_log_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_order_r   <= FIELD_ORDER_RST;
      minus_one_log_r <= MINUS_ONE_RST;
    end else begin
      field_order_r   <= field_order_nxt;
      minus_one_log_r <= minus_one_log_nxt;
    end
  end

  logic q_full;
  logic push;
  dec_t dec;
  logic pop;
  logic head_valid;
  dec_t head;

  gzla_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .field_order (field_order_r),
    .q_full      (q_full),
    .push        (push),
    .dec         (dec)
  );

  gzla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din        (dec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  gzla_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .field_order   (field_order_r),
    .minus_one_log (minus_one_log_r),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule

`default_nettype wire

/* hw/rtl/gzla_front.sv */
// Front end: takes input transactions and classifies them into decoded items.
// Depends on gzla_pkg; feeds gzla_queue.
`default_nettype none

module gzla_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gzla_pkg::IN_DW-1:0]  in_tdata,   // operand_a, operand_b, exponent,
                                                  // table_index, table_value, pad
  input  logic [gzla_pkg::OPW-1:0]    in_tuser,   // cmd
  input  logic [gzla_pkg::VW-1:0]     field_order,
  input  logic                        q_full,
  output logic                        push,
  output gzla_pkg::dec_t              dec
);
  import gzla_pkg::*;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    dec.op     = op_t'(in_tuser);
    dec.a      = in_tdata[A_LSB +: VW];
    dec.b      = in_tdata[B_LSB +: VW];
    dec.e      = in_tdata[E_LSB +: EW];
    dec.idx    = in_tdata[IDX_LSB +: VW];
    dec.tval   = in_tdata[TVAL_LSB +: VW];
    // raw code compares against q mark the field zero
    dec.a_zero = (dec.a == field_order);
    dec.b_zero = (dec.b == field_order);
    dec.e_zero = (dec.e == '0);
    dec.eq     = (dec.a == dec.b);
  end

endmodule

`default_nettype wire

/* hw/rtl/gzla_queue.sv */
// Short queue of decoded items between the front and the back pipeline.
// Depends on gzla_pkg.
`default_nettype none

module gzla_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gzla_pkg::dec_t din,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output gzla_pkg::dec_t head
);
  import gzla_pkg::*;

  dec_t           slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_pop;

  assign full       = (cnt_r == (QAW+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

endmodule

`default_nettype wire

/* hw/rtl/gzla_back.sv */
// Back pipeline: operand reduction, field ops, Zech table, final reduction, result register.
// Depends on gzla_pkg; pops items from gzla_queue.
`default_nettype none

module gzla_back #(
  parameter int TABLE_DEPTH = gzla_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gzla_pkg::VW-1:0]     field_order,
  input  logic [gzla_pkg::VW-1:0]     minus_one_log,
  input  logic                        head_valid,
  input  gzla_pkg::dec_t              head,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gzla_pkg::VW-1:0]     out_tdata,
  output logic [gzla_pkg::OUT_UW-1:0] out_tuser
);
  import gzla_pkg::*;

  localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RA = RED_A_STEPS;
  localparam int RE = RED_E_STEPS;

  typedef struct packed {
    dec_t          d;
    logic [VW-1:0] ar;
    logic [VW-1:0] br;
    logic [VW-1:0] nr;
  } sa_t;

  typedef struct packed {
    tag_t          tag;
    logic          a_zero;
    logic          p2_zero;
    logic [VW-1:0] a;
    logic [VW-1:0] p2;
    logic [VW-1:0] ar;
    logic [VW-1:0] p2_red;
    logic [EW-1:0] e;
    logic [VW-1:0] idx;
    logic [VW-1:0] tval;
  } sb_t;

  typedef struct packed {
    tag_t          tag;
    logic [VW-1:0] lo;
    logic [VW-1:0] d;
    logic [VW-1:0] ar;
    logic [EW-1:0] e;
    logic [VW-1:0] idx;
    logic [VW-1:0] tval;
  } sc_t;

  typedef struct packed {
    tag_t          tag;
    logic [VW-1:0] lo;
  } sd_t;

  typedef struct packed {
    tag_t          tag;
    logic [VW-1:0] lo;
    logic          tz;
    logic [PW-1:0] rem;
  } se_t;

  logic [VW-1:0] q;
  logic [VW-1:0] m;
  logic          adv;

  assign q   = field_order;
  assign m   = (q >= 16'd2) ? q - 16'd1 : 16'd1;
  // whole back advances whenever the result register can take a new value
  assign adv = !out_tvalid || out_tready;
  assign pop = adv && head_valid;

  // ---------------- stage A: reduce a, b and log(-1) mod m ----------------
  sa_t  sa_r   [RA];
  logic sa_vld_r [RA];
  sa_t  sa_in  [RA];
  logic sa_vin [RA];

  always_comb begin
    sa_in[0].d  = head;
    sa_in[0].ar = head.a;
    sa_in[0].br = head.b;
    sa_in[0].nr = minus_one_log;
    sa_vin[0]   = head_valid;
    for (int k = 1; k < RA; k++) begin
      sa_in[k]  = sa_r[k-1];
      sa_vin[k] = sa_vld_r[k-1];
    end
  end

  for (genvar k = 0; k < RA; k++) begin : g_red_a
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sa_vld_r[k] <= 1'b0;
      end else if (adv) begin
        sa_vld_r[k] <= sa_vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sa_r[k].d  <= sa_in[k].d;
        sa_r[k].ar <= red16_step(sa_in[k].ar, m, RA-1-k);
        sa_r[k].br <= red16_step(sa_in[k].br, m, RA-1-k);
        sa_r[k].nr <= red16_step(sa_in[k].nr, m, RA-1-k);
      end
    end
  end

  // ---------------- stage B: direct field ops, negate b ----------------
  sb_t           sb_r, sb_nxt;
  logic          sb_vld_r;
  sa_t           sa_last;
  logic [VW-1:0] negb;

  always_comb begin
    sa_last           = sa_r[RA-1];
    negb              = mod_add(sa_last.br, sa_last.nr, m);
    sb_nxt.tag.op     = sa_last.d.op;
    sb_nxt.tag.eq     = sa_last.d.eq;
    sb_nxt.tag.dz     = 1'b0;
    sb_nxt.tag.direct = 1'b1;
    sb_nxt.tag.res    = '0;
    sb_nxt.a_zero     = sa_last.d.a_zero;
    sb_nxt.a          = sa_last.d.a;
    sb_nxt.ar         = sa_last.ar;
    sb_nxt.e          = sa_last.d.e;
    sb_nxt.idx        = sa_last.d.idx;
    sb_nxt.tval       = sa_last.d.tval;
    sb_nxt.p2         = sa_last.d.b;
    sb_nxt.p2_red     = sa_last.br;
    case (sa_last.d.op)
      OP_ADD: begin
        sb_nxt.tag.direct = 1'b0;
      end
      OP_SUB: begin
        sb_nxt.tag.direct = 1'b0;
        sb_nxt.p2         = sa_last.d.b_zero ? q : negb;
        sb_nxt.p2_red     = negb;
      end
      OP_MUL: begin
        sb_nxt.tag.res = (sa_last.d.a_zero || sa_last.d.b_zero) ? q
                         : mod_add(sa_last.ar, sa_last.br, m);
      end
      OP_DIV: begin
        if (sa_last.d.b_zero) begin
          sb_nxt.tag.res = q;
          sb_nxt.tag.dz  = 1'b1;
        end else if (sa_last.d.a_zero) begin
          sb_nxt.tag.res = q;
        end else begin
          sb_nxt.tag.res = mod_sub(sa_last.ar, sa_last.br, m);
        end
      end
      OP_NEG: begin
        sb_nxt.tag.res = sa_last.d.a_zero ? q : mod_add(sa_last.ar, sa_last.nr, m);
      end
      OP_INV: begin
        if (sa_last.d.a_zero) begin
          sb_nxt.tag.res = q;
          sb_nxt.tag.dz  = 1'b1;
        end else begin
          sb_nxt.tag.res = (sa_last.ar == '0) ? '0 : m - sa_last.ar;
        end
      end
      OP_POW: begin
        if (sa_last.d.e_zero) sb_nxt.tag.res = '0;
        else if (sa_last.d.a_zero) sb_nxt.tag.res = q;
        else sb_nxt.tag.direct = 1'b0;
      end
      default: begin
      end
    endcase
    // a negated operand can itself land on the zero code for tiny q
    sb_nxt.p2_zero = (sb_nxt.p2 == q);
  end

  // ---------------- stage C: zero pass-through, Zech index ----------------
  sc_t sc_r, sc_nxt;
  logic sc_vld_r;

  always_comb begin
    sc_nxt.tag  = sb_r.tag;
    sc_nxt.ar   = sb_r.ar;
    sc_nxt.e    = sb_r.e;
    sc_nxt.idx  = sb_r.idx;
    sc_nxt.tval = sb_r.tval;
    sc_nxt.lo   = (sb_r.ar < sb_r.p2_red) ? sb_r.ar : sb_r.p2_red;
    sc_nxt.d    = (sb_r.ar >= sb_r.p2_red) ? sb_r.ar - sb_r.p2_red : sb_r.p2_red - sb_r.ar;
    if (sb_r.tag.op inside {OP_ADD, OP_SUB}) begin
      if (sb_r.a_zero) begin
        sc_nxt.tag.direct = 1'b1;
        sc_nxt.tag.res    = sb_r.p2;
      end else if (sb_r.p2_zero) begin
        sc_nxt.tag.direct = 1'b1;
        sc_nxt.tag.res    = sb_r.a;
      end
    end
  end

  // ---------------- stage D: table access and pow product ----------------
  logic [VW-1:0] zech_mem [TABLE_DEPTH];
  logic [VW-1:0] t_r;
  logic          d_in_r;
  logic [PW-1:0] prod_r;
  sd_t           sd_r;
  logic          sd_vld_r;
  logic          tbl_wr;

  assign tbl_wr = adv && sc_vld_r && (sc_r.tag.op == OP_LOAD)
                  && (32'(sc_r.idx) < 32'(TABLE_DEPTH));

  // loads and reads share this stage, so table order follows item order
  always_ff @(posedge clk) begin
    if (tbl_wr) zech_mem[sc_r.idx[TW-1:0]] <= sc_r.tval;
    if (adv) t_r <= zech_mem[sc_r.d[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_in_r <= (32'(sc_r.d) < 32'(TABLE_DEPTH));
      prod_r <= PW'(sc_r.ar) * PW'(sc_r.e);
      sd_r   <= '{tag: sc_r.tag, lo: sc_r.lo};
    end
  end

  // ---------------- stage E: reduce Zech entry or product mod m ----------------
  se_t           se_r   [RE];
  logic          se_vld_r [RE];
  se_t           se_in  [RE];
  logic          se_vin [RE];
  logic [VW-1:0] teff;

  always_comb begin
    teff          = d_in_r ? t_r : '0;
    se_in[0].tag  = sd_r.tag;
    se_in[0].lo   = sd_r.lo;
    se_in[0].tz   = (teff == q);
    se_in[0].rem  = (sd_r.tag.op == OP_POW) ? prod_r : PW'(teff);
    se_vin[0]     = sd_vld_r;
    for (int k = 1; k < RE; k++) begin
      se_in[k]  = se_r[k-1];
      se_vin[k] = se_vld_r[k-1];
    end
  end

  for (genvar k = 0; k < RE; k++) begin : g_red_e
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        se_vld_r[k] <= 1'b0;
      end else if (adv) begin
        se_vld_r[k] <= se_vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        se_r[k].tag <= se_in[k].tag;
        se_r[k].lo  <= se_in[k].lo;
        se_r[k].tz  <= se_in[k].tz;
        se_r[k].rem <= red47_step(se_in[k].rem, m, RE-1-k);
      end
    end
  end

  // ---------------- stage F: finish add, sub and pow ----------------
  tag_t sf_r, sf_nxt;
  logic sf_vld_r;
  se_t  se_last;

  always_comb begin
    se_last = se_r[RE-1];
    sf_nxt  = se_last.tag;
    if (!se_last.tag.direct) begin
      if (se_last.tag.op == OP_POW) sf_nxt.res = se_last.rem[VW-1:0];
      else sf_nxt.res = se_last.tz ? q : mod_add(se_last.lo, se_last.rem[VW-1:0], m);
    end
  end

  // ---------------- stage-to-stage registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
      sd_vld_r <= 1'b0;
      sf_vld_r <= 1'b0;
    end else if (adv) begin
      sb_vld_r <= sa_vld_r[RA-1];
      sc_vld_r <= sb_vld_r;
      sd_vld_r <= sc_vld_r;
      sf_vld_r <= se_vld_r[RE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r <= sb_nxt;
      sc_r <= sc_nxt;
      sf_r <= sf_nxt;
    end
  end

  // ---------------- result register ----------------
  logic                out_valid_r;
  logic [VW-1:0]       out_res_r;
  logic [OUT_UW-1:0]   out_flags_r;
  logic [OUT_UW-1:0]   flags_nxt;

  always_comb begin
    flags_nxt          = '0;
    flags_nxt[UB_DZ]   = sf_r.dz;
    flags_nxt[UB_ZERO] = (sf_r.res == q);
    flags_nxt[UB_ONE]  = (sf_r.res == '0);
    flags_nxt[UB_MONE] = (sf_r.res != '0) && (sf_r.res != q) && (sf_r.res == minus_one_log);
    flags_nxt[UB_EQ]   = sf_r.eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      // drop loads: they only touch the table
      out_valid_r <= sf_vld_r && (sf_r.op != OP_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r   <= sf_r.res;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_flags_r;

  // ---------------- checks ----------------
  a_red_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sa_vld_r[RA-1] |-> (sa_r[RA-1].ar < m) && (sa_r[RA-1].br < m) && (sa_r[RA-1].nr < m))
    else $error("operand reduction left a value not below m");

  // only add, sub and pow use the reduced value; other ops may carry an unread table word
  a_red_e_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (se_vld_r[RE-1] && !se_r[RE-1].tag.direct) |-> (se_r[RE-1].rem < PW'(m)))
    else $error("final reduction left a value not below m");

  a_dz_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[UB_DZ]) |-> out_tuser[UB_ZERO])
    else $error("divide by zero result is not the zero code");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(sf_vld_r) && (!sf_vld_r || $stable(sf_r)))
    else $error("pipeline moved while the result register was stalled");

endmodule

`default_nettype wire

/* bench/tb_gf_zech_log_alu_core.sv */
// Self-checking testbench for gf_zech_log_alu_core: directed and random GF(q) log-domain
// transactions over several field settings, checked against an in-bench Zech-log predictor.
// Depends on gzla_pkg and the RTL of gf_zech_log_alu_core only.
`timescale 1ns / 1ps

module tb_gf_zech_log_alu_core;
  import gzla_pkg::*;

  typedef struct packed {
    op_t           cmd;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [EW-1:0] e;
    logic [VW-1:0] idx;
    logic [VW-1:0] tval;
  } alu_item_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          dz;
    logic          is_zero;
    logic          is_one;
    logic          is_mone;
    logic          eq;
  } alu_result_t;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int IDLE_PCT     = 9;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata   = '0;
  logic [OPW-1:0]      in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [VW-1:0]       out_tdata;
  logic [OUT_UW-1:0]   out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index  = '0;
  logic [VW-1:0]       cfg_data   = '0;

  // predictor state
  logic [VW-1:0]       cur_q;
  logic [VW-1:0]       cur_mlog;
  logic [VW-1:0]       zech_mem [DEFAULT_TABLE_DEPTH];

  // stimulus side
  logic [VW-1:0]       ph_q    = FIELD_ORDER_RST;
  logic [VW-1:0]       ph_mlog = MINUS_ONE_RST;
  bit                  loaded [DEFAULT_TABLE_DEPTH];
  alu_item_t           pend_q [$];
  alu_result_t         pending_results [$];
  alu_item_t           drv_item;
  int                  queued_cnt  = 0;
  int                  in_count    = 0;
  int                  err_cnt     = 0;
  int                  quiet_cycles = 0;
  logic                burst_window;

  assign burst_window = (in_count >= 300) && (in_count < 420);

  gf_zech_log_alu_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned log_modulus(input int unsigned q);
    return (q >= 2) ? q - 1 : 1;
  endfunction

  function automatic int unsigned negate_log(input int unsigned c, input int unsigned q,
                                             input int unsigned ml);
    int unsigned m;
    m = log_modulus(q);
    if (c == q) return c;
    return ((c % m) + (ml % m)) % m;
  endfunction

  // Zech table entry that an add or sub reads, or -1 when none is read
  function automatic int zech_slot(input op_t cmd, input int unsigned a, input int unsigned b,
                                   input int unsigned q, input int unsigned ml);
    int unsigned m;
    int unsigned ar;
    int unsigned br;
    if (cmd != OP_ADD && cmd != OP_SUB) return -1;
    m = log_modulus(q);
    br = (cmd == OP_SUB) ? negate_log(b, q, ml) : b;
    if (a == q || br == q) return -1;
    ar = a % m;
    br = br % m;
    return (ar >= br) ? int'(ar - br) : int'(br - ar);
  endfunction

  task automatic predict_item(input alu_item_t it);
    int unsigned      q;
    int unsigned      m;
    int unsigned      a;
    int unsigned      b;
    int unsigned      r;
    int unsigned      t;
    int unsigned      lo;
    longint unsigned  prod;
    logic             dz;
    alu_result_t      res;
    q  = cur_q;
    m  = log_modulus(q);
    a  = it.a;
    b  = it.b;
    r  = 0;
    dz = 1'b0;
    case (it.cmd)
      OP_LOAD: begin
        zech_mem[it.idx] = it.tval;
        return;
      end
      OP_ADD, OP_SUB: begin
        if (it.cmd == OP_SUB) b = negate_log(b, q, cur_mlog);
        if (a == q) r = b;
        else if (b == q) r = a;
        else begin
          lo = ((a % m) < (b % m)) ? a % m : b % m;
          t  = zech_mem[zech_slot(OP_ADD, a, b, q, cur_mlog)];
          r  = (t == q) ? q : (lo + t % m) % m;
        end
      end
      OP_MUL: r = (a == q || b == q) ? q : ((a % m) + (b % m)) % m;
      OP_DIV: begin
        if (b == q) begin
          r  = q;
          dz = 1'b1;
        end else if (a == q) r = q;
        else r = ((a % m) + m - (b % m)) % m;
      end
      OP_NEG: r = negate_log(a, q, cur_mlog);
      OP_INV: begin
        if (a == q) begin
          r  = q;
          dz = 1'b1;
        end else r = (m - (a % m)) % m;
      end
      default: begin
        if (it.e == '0) r = 0;
        else if (a == q) r = q;
        else begin
          prod = longint'(a % m) * longint'(it.e);
          r    = int'(prod % m);
        end
      end
    endcase
    res.value   = r[VW-1:0];
    res.dz      = dz;
    res.is_zero = (r == q);
    res.is_one  = (r == 0);
    res.is_mone = (r != 0) && (r != q) && (r == cur_mlog);
    res.eq      = (it.a == it.b);
    pending_results.push_back(res);
  endtask

  // driver
  always @(posedge clk) begin
    alu_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(drv_item);
        in_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() != 0 && (burst_window || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pend_q.pop_front();
          drv_item = nxt;
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, nxt.tval, nxt.idx, nxt.e, nxt.b, nxt.a};
          in_tuser  <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value   = out_tdata;
        got.dz      = out_tuser[UB_DZ];
        got.is_zero = out_tuser[UB_ZERO];
        got.is_one  = out_tuser[UB_ONE];
        got.is_mone = out_tuser[UB_MONE];
        got.eq      = out_tuser[UB_EQ];
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: value %0d flags %b", out_tdata, out_tuser);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value || got.dz !== want.dz || got.is_zero !== want.is_zero ||
              got.is_one !== want.is_one || got.is_mone !== want.is_mone ||
              got.eq !== want.eq) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: expected value %0d dz %b zero %b one %b mone %b eq %b",
                       want.value, want.dz, want.is_zero, want.is_one, want.is_mone, want.eq);
              $display("          got      value %0d dz %b zero %b one %b mone %b eq %b",
                       got.value, got.dz, got.is_zero, got.is_one, got.is_mone, got.eq);
            end
          end
        end
      end
      out_tready <= burst_window || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // register shadow for the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_q    = FIELD_ORDER_RST;
      cur_mlog = MINUS_ONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIELD_ORDER: cur_q = cfg_data;
        CFG_MINUS_ONE:   cur_mlog = cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_gf_zech_log_alu_core: done, errors");
          $finish;
        end
      end
    end
  end

  function automatic logic [VW-1:0] pick_operand();
    int unsigned m;
    m = log_modulus(ph_q);
    case ($urandom_range(9))
      0: return ph_q;
      1: return '0;
      2: return ph_mlog;
      3: return VW'($urandom);
      4: return VW'(m - 1);
      default: return VW'($urandom_range(m - 1, 0));
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_entry();
    int unsigned m;
    m = log_modulus(ph_q);
    case ($urandom_range(3))
      0: return ph_q;
      1: return VW'($urandom);
      default: return VW'($urandom_range(m - 1, 0));
    endcase
  endfunction

  function automatic logic [EW-1:0] pick_exponent();
    case ($urandom_range(7))
      0: return '0;
      1: return EW'(1);
      2: return '1;
      3: return EW'($urandom_range(20, 2));
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic queue_load(input logic [VW-1:0] idx, input logic [VW-1:0] val);
    alu_item_t it;
    it.cmd  = OP_LOAD;
    it.a    = VW'($urandom);
    it.b    = VW'($urandom);
    it.e    = EW'($urandom);
    it.idx  = idx;
    it.tval = val;
    loaded[idx] = 1'b1;
    pend_q.push_back(it);
    queued_cnt++;
  endtask

  // fill the table entry an add or sub will read before queuing it
  task automatic queue_op(input op_t cmd, input logic [VW-1:0] a, input logic [VW-1:0] b,
                          input logic [EW-1:0] e);
    alu_item_t it;
    int        slot;
    slot = zech_slot(cmd, a, b, ph_q, ph_mlog);
    if (slot >= 0 && !loaded[slot]) queue_load(VW'(slot), pick_entry());
    it.cmd  = cmd;
    it.a    = a;
    it.b    = b;
    it.e    = e;
    it.idx  = VW'($urandom);
    it.tval = VW'($urandom);
    pend_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic queue_random_item();
    op_t           cmd;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    cmd = op_t'($urandom_range(7));
    if (cmd == OP_LOAD) begin
      if ($urandom_range(3) == 0) queue_load(VW'($urandom), pick_entry());
      else queue_load(VW'($urandom_range(log_modulus(ph_q) - 1, 0)), pick_entry());
    end else begin
      a = pick_operand();
      b = ($urandom_range(7) == 0) ? a : pick_operand();
      queue_op(cmd, a, b, pick_exponent());
    end
  endtask

  // hold until every queued transaction is in and every result is out
  task automatic wait_drained();
    while (in_count != queued_cnt || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [VW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [VW-1:0] q, input logic [VW-1:0] ml, input int n);
    wait_drained();
    write_reg(CFG_FIELD_ORDER, q);
    write_reg(CFG_MINUS_ONE, ml);
    ph_q    = q;
    ph_mlog = ml;
    repeat (n) queue_random_item();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(16'd4, 16'd0, 0);
    queue_load(16'd0, 16'd2);
    queue_load(16'hFFFF, 16'hFFFF);
    queue_load(16'd1, 16'd4);        // z^1 + 1 is zero
    queue_load(16'd2, 16'hFFFF);     // entry above q, reduced on use
    queue_op(OP_ADD, 16'd0, 16'd1, '0);
    queue_op(OP_ADD, 16'd4, 16'd2, '1);
    queue_op(OP_ADD, 16'd1, 16'd4, '0);
    queue_op(OP_ADD, 16'd4, 16'd4, '0);
    queue_op(OP_ADD, 16'd0, 16'd2, '0);
    queue_op(OP_SUB, 16'd2, 16'd2, '0);
    queue_op(OP_SUB, 16'hFFFF, 16'd0, '0);
    queue_op(OP_SUB, 16'd4, 16'd1, '0);
    queue_op(OP_MUL, 16'hFFFF, 16'hFFFF, '0);
    queue_op(OP_MUL, 16'd4, 16'd1, '0);
    queue_op(OP_DIV, 16'd1, 16'd4, '0);
    queue_op(OP_DIV, 16'd4, 16'd2, '0);
    queue_op(OP_DIV, 16'd0, 16'd2, '0);
    queue_op(OP_NEG, 16'd4, 16'd0, '0);
    queue_op(OP_NEG, 16'hFFFF, 16'd0, '0);
    queue_op(OP_INV, 16'd4, 16'd0, '0);
    queue_op(OP_INV, 16'd0, 16'd3, '0);
    queue_op(OP_INV, 16'd2, 16'd0, '0);
    queue_op(OP_POW, 16'd4, 16'd0, '0);
    queue_op(OP_POW, 16'd4, 16'd0, '1);
    queue_op(OP_POW, 16'hFFFF, 16'd0, '1);
    queue_op(OP_POW, 16'd2, 16'd5, '0);
    repeat (90) queue_random_item();

    run_phase(16'd65535, 16'd65534, 100);
    run_phase(16'd7, 16'd3, 100);
    run_phase(16'd256, 16'd0, 100);
    run_phase(VW'($urandom_range(65535, 4)), VW'($urandom_range(65534, 0)), 100);
    run_phase(16'd65535, 16'd0, 100);
    run_phase(16'd5, 16'd65534, 100);
    wait_drained();

    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_gf_zech_log_alu_core: done, clean");
    end else begin
      $display("tb_gf_zech_log_alu_core: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/gzla_pkg.sv
hw/rtl/gzla_front.sv
hw/rtl/gzla_queue.sv
hw/rtl/gzla_back.sv
hw/rtl/gf_zech_log_alu_core.sv
bench/tb_gf_zech_log_alu_core.sv
